FILE: rtl/hhac_pkg.sv
// ----------------------------------------------------------------------------
// hhac_pkg
// Types and constants shared by the handle heap allocator and compactor.
// ----------------------------------------------------------------------------
`default_nettype none

package hhac_pkg;

  localparam int unsigned HANDLE_SLOTS = 32;
  localparam int unsigned HIDX_W       = $clog2(HANDLE_SLOTS);
  localparam int unsigned BLOCK_SLOTS  = 64;
  localparam int unsigned BIDX_W       = $clog2(BLOCK_SLOTS);
  localparam int unsigned BCNT_W       = BIDX_W + 1;
  localparam int unsigned HEADER_BYTES = 5;

  localparam logic [15:0] BLK_OVH    = 16'(HEADER_BYTES + 1);
  localparam logic [15:0] HEAP_RESET = 16'd4096;
  localparam logic [15:0] THR_RESET  = 16'd128;

  typedef enum logic [2:0] {
    REQ_ALLOC   = 3'd0,
    REQ_FREE    = 3'd1,
    REQ_RESIZE  = 3'd2,
    REQ_VERIFY  = 3'd3,
    REQ_COMPACT = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOSPACE = 3'd1,
    ST_NOHDL   = 3'd2,
    ST_BADHDL  = 3'd3,
    ST_UNALLOC = 3'd4,
    ST_SKIPPED = 3'd5,
    ST_LISTFUL = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    OP_ALLOC, OP_FREE, OP_RESIZE, OP_VERIFY, OP_COMPACT, OP_NONE
  } op_e;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [14:0] payload_size;
    logic [5:0]  handle_in;
    logic [7:0]  block_kind;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  handle_out;
    logic [15:0] new_offset;
    logic [15:0] old_offset;
    logic [15:0] byte_count;
    logic        last;
    logic [15:0] free_bytes;
    logic [15:0] used_bytes;
    logic [15:0] dirty_bytes;
    logic [15:0] peak_bytes;
    logic [5:0]  live_handles;
    logic [31:0] failed_allocs;
  } res_t;

  typedef struct packed {
    op_e               op;
    logic              bad;
    logic [HIDX_W-1:0] idx;
    logic [14:0]       size;
    logic [7:0]        kind;
  } entry_t;

  typedef struct packed {
    logic              dirty;
    logic [HIDX_W-1:0] hidx;
    logic [14:0]       payload;
  } seq_t;

  typedef struct packed {
    logic [15:0] start;
    logic [14:0] payload;
    logic [7:0]  kind;
  } hent_t;

  typedef struct packed {
    logic [15:0] heap_bytes;
    logic [15:0] threshold;
    logic        reinit;
  } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/hhac_ram.sv
// ----------------------------------------------------------------------------
// hhac_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hhac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: rtl/hhac_front.sv
// ----------------------------------------------------------------------------
// hhac_front
// Accepts request items, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
`default_nettype none

module hhac_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire hhac_pkg::req_t  req_i,
  output logic                 busy_o,
  input  wire logic            pop_i,
  output logic                 empty_o,
  output hhac_pkg::entry_t     head_o
);

  hhac_pkg::entry_t q_q [2];
  logic             wp_q, rp_q;
  logic [1:0]       cnt_q;
  hhac_pkg::entry_t cls;
  logic             push;

  always_comb begin
    cls.size = req_i.payload_size;
    cls.kind = req_i.block_kind;
    cls.idx  = hhac_pkg::HIDX_W'(req_i.handle_in - 6'd1);
    cls.bad  = (req_i.handle_in == 6'd0) ||
               (req_i.handle_in > 6'(hhac_pkg::HANDLE_SLOTS));
    unique case (req_i.req_type)
      hhac_pkg::REQ_ALLOC:   cls.op = hhac_pkg::OP_ALLOC;
      hhac_pkg::REQ_FREE:    cls.op = hhac_pkg::OP_FREE;
      hhac_pkg::REQ_RESIZE:  cls.op = hhac_pkg::OP_RESIZE;
      hhac_pkg::REQ_VERIFY:  cls.op = hhac_pkg::OP_VERIFY;
      hhac_pkg::REQ_COMPACT: cls.op = hhac_pkg::OP_COMPACT;
      default:               cls.op = hhac_pkg::OP_NONE;
    endcase
  end

  assign busy_o  = cnt_q[1];
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = q_q[rp_q];
  assign push    = start_i && !busy_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + 2'(push) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hhac_back.sv
// ----------------------------------------------------------------------------
// hhac_back
// Carries out queued items against the handle table and the block list.
// ----------------------------------------------------------------------------
`default_nettype none

module hhac_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hhac_pkg::cfg_t   cfg_i,
  input  wire logic             empty_i,
  input  wire hhac_pkg::entry_t head_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  output hhac_pkg::res_t        res_o
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EXEC    = 9'b000000010,
    S_HRD     = 9'b000000100,
    S_SCAN_RD = 9'b000001000,
    S_SCAN_CK = 9'b000010000,
    S_FINISH  = 9'b000100000,
    S_CP_RD   = 9'b001000000,
    S_CP_SEQ  = 9'b010000000,
    S_CP_MOVE = 9'b100000000
  } state_e;

  localparam int unsigned HW = hhac_pkg::HIDX_W;
  localparam int unsigned BW = hhac_pkg::BIDX_W;
  localparam int unsigned CW = hhac_pkg::BCNT_W;

  state_e state_q, state_d;
  hhac_pkg::entry_t ent_q, ent_d;
  hhac_pkg::hent_t  hd_q, hd_d;
  hhac_pkg::seq_t   e_q, e_d;
  logic [CW-1:0] b_q, b_d, wr_q, wr_d, total_q, total_d;
  logic [15:0] dst_q, dst_d, oldfp_q, oldfp_d, rec_q, rec_d;
  logic seen_q, seen_d;
  logic [15:0] fp_q, fp_d, free_q, free_d, used_q, used_d;
  logic [15:0] dirty_q, dirty_d, peak_q, peak_d;
  logic [5:0] lcnt_q, lcnt_d;
  logic [31:0] fail_q, fail_d;
  logic [hhac_pkg::HANDLE_SLOTS-1:0] live_q, live_d;
  hhac_pkg::res_t res_q, res_d;
  logic res_v_q, res_v_d;

  logic h_we, s_we;
  logic [HW-1:0] h_waddr, h_raddr;
  logic [BW-1:0] s_waddr;
  hhac_pkg::hent_t h_wdata, h_rdata;
  hhac_pkg::seq_t  s_wdata, s_rdata;

  logic [HW-1:0] free_idx;
  logic [15:0] nbs, obs, ebs, u1;

  function automatic hhac_pkg::res_t mk(input logic [2:0] st, input logic [5:0] h,
                                        input logic [15:0] no, input logic [15:0] oo,
                                        input logic [15:0] cnt, input logic lst);
    hhac_pkg::res_t r;
    r = '0;
    r.status = st;
    r.handle_out = h;
    r.new_offset = no;
    r.old_offset = oo;
    r.byte_count = cnt;
    r.last = lst;
    return r;
  endfunction

  hhac_ram #(.WIDTH($bits(hhac_pkg::hent_t)), .DEPTH(hhac_pkg::HANDLE_SLOTS)) u_hram (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(h_wdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata)
  );

  hhac_ram #(.WIDTH($bits(hhac_pkg::seq_t)), .DEPTH(hhac_pkg::BLOCK_SLOTS)) u_sram (
    .clk_i, .we_i(s_we), .waddr_i(s_waddr), .wdata_i(s_wdata),
    .raddr_i(b_q[BW-1:0]), .rdata_o(s_rdata)
  );

  assign h_raddr = (state_q == S_CP_SEQ) ? s_rdata.hidx : ent_q.idx;

  always_comb begin
    free_idx = '0;
    for (int i = hhac_pkg::HANDLE_SLOTS - 1; i >= 0; i--) begin
      if (!live_q[i]) begin
        free_idx = HW'(i);
      end
    end
  end

  assign nbs = 16'(ent_q.size) + hhac_pkg::BLK_OVH;
  assign obs = 16'(hd_q.payload) + hhac_pkg::BLK_OVH;
  assign ebs = 16'(e_q.payload) + hhac_pkg::BLK_OVH;
  assign u1  = used_q + nbs;

  always_comb begin
    state_d = state_q; ent_d = ent_q; hd_d = hd_q; e_d = e_q;
    b_d = b_q; wr_d = wr_q; total_d = total_q; dst_d = dst_q;
    oldfp_d = oldfp_q; rec_d = rec_q; seen_d = seen_q;
    fp_d = fp_q; free_d = free_q; used_d = used_q; dirty_d = dirty_q;
    peak_d = peak_q; lcnt_d = lcnt_q; fail_d = fail_q; live_d = live_q;
    res_d = res_q; res_v_d = 1'b0; pop_o = 1'b0;
    h_we = 1'b0; h_waddr = ent_q.idx; h_wdata = '0;
    s_we = 1'b0; s_waddr = total_q[BW-1:0]; s_wdata = '0;

    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          ent_d   = head_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        res_v_d = 1'b1;
        unique case (ent_q.op)
          hhac_pkg::OP_ALLOC: begin
            if (free_q < nbs || &live_q || total_q >= CW'(hhac_pkg::BLOCK_SLOTS)) begin
              fail_d = fail_q + 32'd1;
              res_d = mk(free_q < nbs ? hhac_pkg::ST_NOSPACE :
                         (&live_q ? hhac_pkg::ST_NOHDL : hhac_pkg::ST_LISTFUL),
                         6'd0, 16'd0, 16'd0, 16'd0, 1'b1);
            end else begin
              live_d[free_idx] = 1'b1;
              lcnt_d  = lcnt_q + 6'd1;
              h_we    = 1'b1;
              h_waddr = free_idx;
              h_wdata = '{start: fp_q, payload: ent_q.size, kind: ent_q.kind};
              s_we    = 1'b1;
              s_wdata = '{dirty: 1'b0, hidx: free_idx, payload: ent_q.size};
              total_d = total_q + CW'(1);
              fp_d    = fp_q + nbs;
              free_d  = free_q - nbs;
              used_d  = u1;
              if (u1 > peak_q) begin
                peak_d = u1;
              end
              res_d = mk(hhac_pkg::ST_OK, 6'(free_idx) + 6'd1, fp_q, 16'd0,
                         16'(ent_q.size), 1'b1);
            end
          end
          hhac_pkg::OP_FREE, hhac_pkg::OP_VERIFY, hhac_pkg::OP_RESIZE: begin
            if (ent_q.bad) begin
              res_d = mk(hhac_pkg::ST_BADHDL, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1);
            end else if (!live_q[ent_q.idx]) begin
              res_d = mk(hhac_pkg::ST_UNALLOC, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1);
            end else if (ent_q.op == hhac_pkg::OP_RESIZE &&
                         (free_q < nbs || total_q >= CW'(hhac_pkg::BLOCK_SLOTS))) begin
              fail_d = fail_q + 32'd1;
              res_d = mk(free_q < nbs ? hhac_pkg::ST_NOSPACE : hhac_pkg::ST_LISTFUL,
                         6'd0, 16'd0, 16'd0, 16'd0, 1'b1);
            end else begin
              res_v_d = 1'b0;
              state_d = S_HRD;
            end
          end
          hhac_pkg::OP_COMPACT: begin
            if (dirty_q < cfg_i.threshold) begin
              res_d = mk(hhac_pkg::ST_SKIPPED, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1);
            end else begin
              res_v_d = 1'b0;
              oldfp_d = fp_q;
              rec_d   = dirty_q;
              free_d  = free_q + dirty_q;
              dirty_d = 16'd0;
              b_d = '0; wr_d = '0; dst_d = 16'd0; seen_d = 1'b0;
              state_d = S_CP_RD;
            end
          end
          default: begin
            res_d = mk(hhac_pkg::ST_OK, 6'd0, 16'd0, 16'd0, 16'd0, 1'b1);
          end
        endcase
      end
      S_HRD: begin
        hd_d = h_rdata;
        if (ent_q.op == hhac_pkg::OP_VERIFY) begin
          res_v_d = 1'b1;
          res_d = mk(hhac_pkg::ST_OK, 6'(ent_q.idx) + 6'd1, h_rdata.start, 16'd0,
                     16'(h_rdata.payload), 1'b1);
          state_d = S_IDLE;
        end else begin
          b_d = '0;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_d = (b_q < total_q) ? S_SCAN_CK : S_FINISH;
      end
      S_SCAN_CK: begin
        if (!s_rdata.dirty && s_rdata.hidx == ent_q.idx) begin
          s_we    = 1'b1;
          s_waddr = b_q[BW-1:0];
          s_wdata = s_rdata;
          s_wdata.dirty = 1'b1;
          state_d = S_FINISH;
        end else begin
          b_d = b_q + CW'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
        res_v_d = 1'b1;
        dirty_d = dirty_q + obs;
        if (ent_q.op == hhac_pkg::OP_FREE) begin
          used_d = used_q - obs;
          live_d[ent_q.idx] = 1'b0;
          lcnt_d = lcnt_q - 6'd1;
          res_d = mk(hhac_pkg::ST_OK, 6'(ent_q.idx) + 6'd1, hd_q.start, 16'd0,
                     16'(hd_q.payload), 1'b1);
        end else begin
          h_we    = 1'b1;
          h_wdata = '{start: fp_q, payload: ent_q.size, kind: hd_q.kind};
          s_we    = 1'b1;
          s_wdata = '{dirty: 1'b0, hidx: ent_q.idx, payload: ent_q.size};
          total_d = total_q + CW'(1);
          fp_d    = fp_q + nbs;
          free_d  = free_q - nbs;
          used_d  = u1 - obs;
          if (u1 > peak_q) begin
            peak_d = u1;
          end
          res_d = mk(hhac_pkg::ST_OK, 6'(ent_q.idx) + 6'd1, fp_q, hd_q.start,
                     (hd_q.payload < ent_q.size) ? 16'(hd_q.payload) : 16'(ent_q.size),
                     1'b1);
        end
      end
      S_CP_RD: begin
        if (b_q < total_q) begin
          state_d = S_CP_SEQ;
        end else begin
          total_d = wr_q;
          fp_d    = dst_q;
          res_v_d = 1'b1;
          res_d   = mk(hhac_pkg::ST_OK, 6'd0, dst_q, oldfp_q, rec_q, 1'b1);
          state_d = S_IDLE;
        end
      end
      S_CP_SEQ: begin
        e_d = s_rdata;
        if (s_rdata.dirty) begin
          seen_d  = 1'b1;
          b_d     = b_q + CW'(1);
          state_d = S_CP_RD;
        end else begin
          state_d = S_CP_MOVE;
        end
      end
      S_CP_MOVE: begin
        if (seen_q) begin
          res_v_d = 1'b1;
          res_d = mk(hhac_pkg::ST_OK, 6'(e_q.hidx) + 6'd1, dst_q, h_rdata.start, ebs, 1'b0);
        end
        h_we    = 1'b1;
        h_waddr = e_q.hidx;
        h_wdata = '{start: dst_q, payload: h_rdata.payload, kind: h_rdata.kind};
        s_we    = 1'b1;
        s_waddr = wr_q[BW-1:0];
        s_wdata = e_q;
        wr_d    = wr_q + CW'(1);
        dst_d   = dst_q + ebs;
        b_d     = b_q + CW'(1);
        state_d = S_CP_RD;
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_i.reinit) begin
      live_d = '0; total_d = '0; fp_d = 16'd0; free_d = cfg_i.heap_bytes;
      used_d = 16'd0; dirty_d = 16'd0; lcnt_d = 6'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d; hd_q <= hd_d; e_q <= e_d;
    b_q <= b_d; wr_q <= wr_d; dst_q <= dst_d;
    oldfp_q <= oldfp_d; rec_q <= rec_d; seen_q <= seen_d;
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      total_q <= '0;
      fp_q    <= 16'd0;
      free_q  <= hhac_pkg::HEAP_RESET;
      used_q  <= 16'd0;
      dirty_q <= 16'd0;
      peak_q  <= 16'd0;
      lcnt_q  <= 6'd0;
      fail_q  <= 32'd0;
      live_q  <= '0;
      res_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      total_q <= total_d;
      fp_q    <= fp_d;
      free_q  <= free_d;
      used_q  <= used_d;
      dirty_q <= dirty_d;
      peak_q  <= peak_d;
      lcnt_q  <= lcnt_d;
      fail_q  <= fail_d;
      live_q  <= live_d;
      res_v_q <= res_v_d;
    end
  end

  always_comb begin
    res_o = res_q;
    res_o.free_bytes    = free_q;
    res_o.used_bytes    = used_q;
    res_o.dirty_bytes   = dirty_q;
    res_o.peak_bytes    = peak_q;
    res_o.live_handles  = lcnt_q;
    res_o.failed_allocs = fail_q;
  end
  assign res_valid_o = res_v_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state register is not one-hot");

  a_live_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(lcnt_q) == 32'($countones(live_q)))
    else $error("live handle count disagrees with the live bits");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(hhac_pkg::BLOCK_SLOTS)) else $error("block list overflow");

  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CP_RD || state_q == S_CP_MOVE) |-> wr_q <= b_q)
    else $error("compaction write index overtook the read index");

endmodule

`default_nettype wire

FILE: rtl/handle_heap_allocator_compactor_core.sv
// ----------------------------------------------------------------------------
// handle_heap_allocator_compactor_core
// Handle-based heap metadata manager with allocation, free, resize, verify
// and compaction, configured over an APB-style register port.
// ----------------------------------------------------------------------------
// Allocate, verify and failing items give their result without a list walk;
// free and resize walk the block list one block at a time, and compaction
// reads every block in the list and moves each live one down. The back end
// finishes one item before it takes the next from a two-item queue; results
// are strobed for one cycle. Reset clears all handles and blocks at once.
`default_nettype none

module handle_heap_allocator_compactor_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  output logic                 busy_o,
  input  wire hhac_pkg::req_t  req_i,
  output logic                 res_valid_o,
  output hhac_pkg::res_t       res_o,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  logic [15:0] heap_q, thr_q;
  logic        wr_en;
  hhac_pkg::cfg_t   cfg;
  hhac_pkg::entry_t head;
  logic             empty, pop;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign prdata = {16'd0, paddr[2] ? thr_q : heap_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_q <= hhac_pkg::HEAP_RESET;
      thr_q  <= hhac_pkg::THR_RESET;
    end else if (wr_en) begin
      if (paddr[2]) begin
        thr_q <= pwdata[15:0];
      end else begin
        heap_q <= pwdata[15:0];
      end
    end
  end

  assign cfg = '{heap_bytes: pwdata[15:0], threshold: thr_q,
                 reinit: wr_en && !paddr[2]};

  hhac_front u_front (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o,
    .pop_i(pop), .empty_o(empty), .head_o(head)
  );

  hhac_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg), .empty_i(empty), .head_i(head),
    .pop_o(pop), .res_valid_o, .res_o
  );

endmodule

`default_nettype wire
